[rtl/mlfqs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, command/status structs and state type for the MLFQS estimator.
package mlfqs_pkg;

  // Fixed-point format and table geometry
  localparam int FRAC_BITS    = 14;
  localparam int SLOT_COUNT   = 64;
  localparam int SLOT_BITS    = $clog2(SLOT_COUNT);
  localparam int TOP_PRIORITY = 63;

  // Load blend coefficients, given with COEF_BITS fraction bits
  localparam int COEF_BITS = 14;
  localparam int LOAD_KEEP = 16111;
  localparam int LOAD_ADD  = 273;
  localparam int ADD_SHL   = (FRAC_BITS >= COEF_BITS) ? (FRAC_BITS - COEF_BITS) : 0;
  localparam int ADD_SHR   = (FRAC_BITS < COEF_BITS) ? (COEF_BITS - FRAC_BITS) : 0;

  // Divider iteration counter
  localparam int CNT_BITS = $clog2(FRAC_BITS);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int SLOT_W  = 6;
  localparam int READY_W = 7;
  localparam int NICE_W  = 6;
  localparam int PRIO_W  = 6;
  localparam int RCPU_W  = 32;
  localparam int LAVG_W  = 13;
  localparam int LOAD_W  = 31;

  localparam int NICE_MIN = -20;
  localparam int NICE_MAX = 20;

  // Event codes
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DECAY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NICE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRIO  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_DECAY,
    ST_ROUND,
    ST_PRIO,
    ST_OUT_MUL,
    ST_OUT_RND
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_step;
    logic mul;
    logic decay;
    logic round;
    logic prio;
    logic out_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              div_last;
    logic              out_free;
  } status_t;

endpackage

[rtl/mlfqs_load_and_cpu_accounting.sv]
`timescale 1ns / 1ps
// Top level of the MLFQS load and recent-CPU estimator.
//
// Usage:
//   One input item is one scheduler event (tick, load update, decay, set nice,
//   recompute priority) for one thread slot; each event yields exactly one
//   result item with the slot's priority, recent CPU x100, nice, and the load
//   estimate x100. Both channels use valid/stall; an item moves on an edge
//   with valid high and stall low.
// Sequencing (accept to result valid): every event is captured, executed and
//   scaled for output; set nice and recompute add a rounding and a priority step;
//   decay adds the bit-serial coefficient divider, a multiply and a decay step.
//   One event is in work at a time; the next is taken only after the result
//   is loaded and the sequencer is back in idle.
// Stall: the result sits in an output register, so a stalled receiver does
//   not block the next input item; work only waits at the end if the output
//   register still holds an untaken result.
// Reset: synchronous; load is zero, all slots read as recent 0, nice 0 and
//   top priority right away (per-slot written marks, no clearing pass).
module mlfqs_load_and_cpu_accounting (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mlfqs_pkg::KIND_W-1:0]        kind,
  input  logic [mlfqs_pkg::SLOT_W-1:0]        slot,
  input  logic                                running_is_idle,
  input  logic [mlfqs_pkg::READY_W-1:0]       ready_count,
  input  logic signed [mlfqs_pkg::NICE_W-1:0] nice_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mlfqs_pkg::PRIO_W-1:0]        priority_res,
  output logic signed [mlfqs_pkg::RCPU_W-1:0] recent_cpu_x100,
  output logic [mlfqs_pkg::LAVG_W-1:0]        load_avg_x100,
  output logic signed [mlfqs_pkg::NICE_W-1:0] nice_out
);

  // Command and status between the sequencer and the datapath
  mlfqs_pkg::cmd_t    cmd;
  mlfqs_pkg::status_t status;

  // Sequencer: one event at a time, stall the input while busy
  mlfqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath: tables, load register, divider, multipliers, output register
  mlfqs_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .kind            (kind),
    .slot            (slot),
    .running_is_idle (running_is_idle),
    .ready_count     (ready_count),
    .nice_value      (nice_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .priority_res    (priority_res),
    .recent_cpu_x100 (recent_cpu_x100),
    .load_avg_x100   (load_avg_x100),
    .nice_out        (nice_out)
  );

  // An accepted item keeps the input stalled until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting an item");

  // Never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // Stored nice values stay within the clamp range
  a_nice_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(nice_out) >= -6'sd20 && $signed(nice_out) <= 6'sd20))
    else $error("nice out of range");

endmodule

[rtl/mlfqs_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer that steps one event through the datapath.
module mlfqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mlfqs_pkg::status_t status,
  output logic               in_stall,
  output mlfqs_pkg::cmd_t    cmd
);

  mlfqs_pkg::state_t state;
  mlfqs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlfqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mlfqs_pkg::ST_IDLE: begin
        if (in_valid) state_next = mlfqs_pkg::ST_EXEC;
      end
      mlfqs_pkg::ST_EXEC: begin
        case (status.kind)
          mlfqs_pkg::KIND_DECAY: state_next = mlfqs_pkg::ST_DIV;
          mlfqs_pkg::KIND_NICE:  state_next = mlfqs_pkg::ST_ROUND;
          mlfqs_pkg::KIND_PRIO:  state_next = mlfqs_pkg::ST_ROUND;
          default:               state_next = mlfqs_pkg::ST_OUT_MUL;
        endcase
      end
      mlfqs_pkg::ST_DIV: begin
        if (status.div_last) state_next = mlfqs_pkg::ST_MUL;
      end
      mlfqs_pkg::ST_MUL:     state_next = mlfqs_pkg::ST_DECAY;
      mlfqs_pkg::ST_DECAY:   state_next = mlfqs_pkg::ST_OUT_MUL;
      mlfqs_pkg::ST_ROUND:   state_next = mlfqs_pkg::ST_PRIO;
      mlfqs_pkg::ST_PRIO:    state_next = mlfqs_pkg::ST_OUT_MUL;
      mlfqs_pkg::ST_OUT_MUL: state_next = mlfqs_pkg::ST_OUT_RND;
      mlfqs_pkg::ST_OUT_RND: begin
        if (status.out_free) state_next = mlfqs_pkg::ST_IDLE;
      end
      default: state_next = mlfqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != mlfqs_pkg::ST_IDLE);
    cmd.capture   = (state == mlfqs_pkg::ST_IDLE) && in_valid;
    cmd.exec      = (state == mlfqs_pkg::ST_EXEC);
    cmd.div_start = (state == mlfqs_pkg::ST_EXEC) && (status.kind == mlfqs_pkg::KIND_DECAY);
    cmd.div_step  = (state == mlfqs_pkg::ST_DIV);
    cmd.mul       = (state == mlfqs_pkg::ST_MUL);
    cmd.decay     = (state == mlfqs_pkg::ST_DECAY);
    cmd.round     = (state == mlfqs_pkg::ST_ROUND);
    cmd.prio      = (state == mlfqs_pkg::ST_PRIO);
    cmd.out_mul   = (state == mlfqs_pkg::ST_OUT_MUL);
    cmd.out_load  = (state == mlfqs_pkg::ST_OUT_RND) && status.out_free;
  end

endmodule

[rtl/mlfqs_div.sv]
`timescale 1ns / 1ps
// Restoring divider for the decay coefficient 2L*F/(2L+F), one quotient bit per cycle.
module mlfqs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           step,
  input  logic [mlfqs_pkg::LOAD_W:0]     dbl,
  output logic [mlfqs_pkg::FRAC_BITS-1:0] quo,
  output logic                           last
);

  localparam int DEN_W = mlfqs_pkg::LOAD_W + 2;

  logic [DEN_W-1:0]              rem;
  logic [DEN_W-1:0]              den;
  logic [DEN_W:0]                trial;
  logic                          fits;
  logic [mlfqs_pkg::CNT_BITS-1:0] cnt;

  always_comb begin
    trial = {rem, 1'b0};
    fits  = (trial >= {1'b0, den});
    last  = (cnt == mlfqs_pkg::CNT_BITS'(mlfqs_pkg::FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Remainder starts at 2L (below the divisor), so every step yields a fraction bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_W'(dbl);
      den <= DEN_W'(dbl) + (DEN_W'(1) << mlfqs_pkg::FRAC_BITS);
      quo <= '0;
    end else if (step) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
        quo <= {quo[mlfqs_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[mlfqs_pkg::FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/mlfqs_dp.sv]
`timescale 1ns / 1ps
// Datapath: slot tables, load register, arithmetic steps and output register.
module mlfqs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mlfqs_pkg::cmd_t                     cmd,
  output mlfqs_pkg::status_t                  status,
  input  logic [mlfqs_pkg::KIND_W-1:0]        kind,
  input  logic [mlfqs_pkg::SLOT_W-1:0]        slot,
  input  logic                                running_is_idle,
  input  logic [mlfqs_pkg::READY_W-1:0]       ready_count,
  input  logic signed [mlfqs_pkg::NICE_W-1:0] nice_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [mlfqs_pkg::PRIO_W-1:0]        priority_res,
  output logic signed [mlfqs_pkg::RCPU_W-1:0] recent_cpu_x100,
  output logic [mlfqs_pkg::LAVG_W-1:0]        load_avg_x100,
  output logic signed [mlfqs_pkg::NICE_W-1:0] nice_out
);

  localparam int F       = mlfqs_pkg::FRAC_BITS;
  localparam int PROD_W  = F + 1 + mlfqs_pkg::RCPU_W;
  localparam int RND_W   = mlfqs_pkg::RCPU_W - 1 - F;
  localparam int PV_W    = RND_W + 4;
  localparam int KPROD_W = mlfqs_pkg::LOAD_W + 14;
  localparam int MR_W    = mlfqs_pkg::RCPU_W + 8;
  localparam int ML_W    = mlfqs_pkg::LOAD_W + 7;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end else if (v[33]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

  // Latched event
  logic [mlfqs_pkg::KIND_W-1:0]        kind_r;
  logic [mlfqs_pkg::SLOT_BITS-1:0]     slot_r;
  logic                                idle_r;
  logic [mlfqs_pkg::READY_W-1:0]       ready_r;
  logic signed [mlfqs_pkg::NICE_W-1:0] nv_r;

  // Slot tables and per-slot written marks
  logic signed [31:0]                  recent_mem [mlfqs_pkg::SLOT_COUNT];
  logic signed [mlfqs_pkg::NICE_W-1:0] nice_mem   [mlfqs_pkg::SLOT_COUNT];
  logic [mlfqs_pkg::PRIO_W-1:0]        prio_mem   [mlfqs_pkg::SLOT_COUNT];
  logic [mlfqs_pkg::SLOT_COUNT-1:0]    written;

  logic signed [31:0]                  rd_recent;
  logic signed [mlfqs_pkg::NICE_W-1:0] rd_nice;
  logic [mlfqs_pkg::PRIO_W-1:0]        rd_prio;
  logic                                rd_valid;

  logic signed [31:0]                  cur_recent;
  logic signed [mlfqs_pkg::NICE_W-1:0] cur_nice;
  logic [mlfqs_pkg::PRIO_W-1:0]        cur_prio;

  // Working copy of the slot and the load estimate
  logic signed [31:0]                  w_recent;
  logic signed [mlfqs_pkg::NICE_W-1:0] w_nice;
  logic [mlfqs_pkg::PRIO_W-1:0]        w_prio;
  logic [mlfqs_pkg::LOAD_W-1:0]        load;

  logic signed [31:0]                  tick_val;
  logic signed [mlfqs_pkg::NICE_W-1:0] nice_clamp;
  logic [KPROD_W-1:0]                  keep_prod;
  logic [7:0]                          run_n;
  logic [31:0]                         add_fp;
  logic [32:0]                         load_sum;
  logic [mlfqs_pkg::LOAD_W-1:0]        load_next;

  logic [F-1:0]                        coef;
  logic                                div_last;
  logic signed [PROD_W-1:0]            dec_prod;
  logic signed [PROD_W-1:0]            dec_adj;
  logic signed [PROD_W-F-1:0]          dec_scaled;
  logic signed [33:0]                  nice_fp;
  logic signed [31:0]                  decay_val;

  logic [31:0]                         r_abs;
  logic [30:0]                         r_sum;
  logic [RND_W-1:0]                    rnd_mag;
  logic                                rnd_neg;
  logic signed [PV_W-1:0]              rnd_s;
  logic signed [PV_W-1:0]              pval;
  logic [mlfqs_pkg::PRIO_W-1:0]        prio_val;

  logic signed [MR_W-1:0]              mul_recent;
  logic [ML_W-1:0]                     mul_load;
  logic [MR_W-1:0]                     mr_abs;
  logic [MR_W-1:0]                     mr_rnd;
  logic signed [31:0]                  recent_fin;
  logic [ML_W-1:0]                     ml_rnd;

  assign status.kind     = kind_r;
  assign status.div_last = div_last;
  assign status.out_free = !out_valid || !out_stall;

  mlfqs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .step  (cmd.div_step),
    .dbl   ({load, 1'b0}),
    .quo   (coef),
    .last  (div_last)
  );

  // Capture the event and read the slot
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= kind;
      slot_r    <= slot[mlfqs_pkg::SLOT_BITS-1:0];
      idle_r    <= running_is_idle;
      ready_r   <= ready_count;
      nv_r      <= nice_value;
      rd_recent <= recent_mem[slot[mlfqs_pkg::SLOT_BITS-1:0]];
      rd_nice   <= nice_mem[slot[mlfqs_pkg::SLOT_BITS-1:0]];
      rd_prio   <= prio_mem[slot[mlfqs_pkg::SLOT_BITS-1:0]];
      rd_valid  <= written[slot[mlfqs_pkg::SLOT_BITS-1:0]];
    end
  end

  // Write back the whole slot once per event
  always_ff @(posedge clk) begin
    if (cmd.out_mul) begin
      recent_mem[slot_r] <= w_recent;
      nice_mem[slot_r]   <= w_nice;
      prio_mem[slot_r]   <= w_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (cmd.out_mul) begin
      written[slot_r] <= 1'b1;
    end
  end

  // Unwritten slots read as their reset values
  always_comb begin
    cur_recent = rd_valid ? rd_recent : '0;
    cur_nice   = rd_valid ? rd_nice : '0;
    cur_prio   = rd_valid ? rd_prio : mlfqs_pkg::PRIO_W'(mlfqs_pkg::TOP_PRIORITY);
  end

  // Tick, set nice and load update
  always_comb begin
    tick_val = sat32(34'(cur_recent) + (34'sd1 <<< F));
    if (nv_r < mlfqs_pkg::NICE_W'(mlfqs_pkg::NICE_MIN)) begin
      nice_clamp = mlfqs_pkg::NICE_W'(mlfqs_pkg::NICE_MIN);
    end else if (nv_r > mlfqs_pkg::NICE_W'(mlfqs_pkg::NICE_MAX)) begin
      nice_clamp = mlfqs_pkg::NICE_W'(mlfqs_pkg::NICE_MAX);
    end else begin
      nice_clamp = nv_r;
    end
    keep_prod = KPROD_W'(load) * KPROD_W'(mlfqs_pkg::LOAD_KEEP);
    run_n     = 8'(ready_r) + 8'(!idle_r);
    add_fp    = ((32'(run_n) * 32'(mlfqs_pkg::LOAD_ADD)) << mlfqs_pkg::ADD_SHL)
                >> mlfqs_pkg::ADD_SHR;
    load_sum  = 33'(keep_prod >> mlfqs_pkg::COEF_BITS) + 33'(add_fp);
    load_next = (load_sum[32:31] != 2'b00) ? '1 : load_sum[mlfqs_pkg::LOAD_W-1:0];
  end

  // Decay: truncate the product toward zero, then add nice
  always_comb begin
    dec_adj    = dec_prod + (dec_prod[PROD_W-1] ? PROD_W'((1 << F) - 1) : PROD_W'(0));
    dec_scaled = dec_adj[PROD_W-1:F];
    nice_fp    = 34'(w_nice) <<< F;
    decay_val  = sat32(34'(dec_scaled) + nice_fp);
  end

  // Priority: round(recent/4) by magnitude, then clamp
  always_comb begin
    r_abs = w_recent[31] ? 32'(-w_recent) : 32'(w_recent);
    r_sum = 31'(r_abs >> 2) + (31'(1) << (F - 1));
    rnd_s = rnd_neg ? -$signed(PV_W'(rnd_mag)) : $signed(PV_W'(rnd_mag));
    pval  = PV_W'(mlfqs_pkg::TOP_PRIORITY) - rnd_s - (PV_W'(w_nice) <<< 1);
    if (pval < 0) begin
      prio_val = '0;
    end else if (pval > PV_W'(mlfqs_pkg::TOP_PRIORITY)) begin
      prio_val = mlfqs_pkg::PRIO_W'(mlfqs_pkg::TOP_PRIORITY);
    end else begin
      prio_val = pval[mlfqs_pkg::PRIO_W-1:0];
    end
  end

  // Output scaling: round(x*100) by magnitude
  always_comb begin
    mr_abs     = mul_recent[MR_W-1] ? MR_W'(-mul_recent) : MR_W'(mul_recent);
    mr_rnd     = (mr_abs + (MR_W'(1) << (F - 1))) >> F;
    recent_fin = mul_recent[MR_W-1] ? -$signed(mr_rnd[31:0]) : $signed(mr_rnd[31:0]);
    ml_rnd     = (mul_load + (ML_W'(1) << (F - 1))) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else if (cmd.exec && kind_r == mlfqs_pkg::KIND_LOAD) begin
      load <= load_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      w_recent <= cur_recent;
      w_nice   <= cur_nice;
      w_prio   <= cur_prio;
      if (kind_r == mlfqs_pkg::KIND_TICK && !idle_r) w_recent <= tick_val;
      if (kind_r == mlfqs_pkg::KIND_NICE) w_nice <= nice_clamp;
    end
    if (cmd.mul) dec_prod <= $signed({1'b0, coef}) * w_recent;
    if (cmd.decay) w_recent <= decay_val;
    if (cmd.round) begin
      rnd_mag <= r_sum[30:F];
      rnd_neg <= w_recent[31];
    end
    if (cmd.prio) w_prio <= prio_val;
    if (cmd.out_mul) begin
      mul_recent <= w_recent * $signed(8'd100);
      mul_load   <= ML_W'(load) * ML_W'(100);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      priority_res    <= w_prio;
      nice_out        <= w_nice;
      recent_cpu_x100 <= recent_fin;
      load_avg_x100   <= ml_rnd[mlfqs_pkg::LAVG_W-1:0];
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the scheduler load and recent-CPU estimator.
module testbench;
  import mlfqs_pkg::*;

  // Unused event codes: the block must report the slot and change nothing
  localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  // Load blend coefficients, 14 fraction bits, held apart from the RTL's copy
  localparam longint BLEND_KEEP = 16111;
  localparam longint BLEND_ADD  = 273;
  localparam int     BLEND_FRAC = 14;

  localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  localparam int ITEM_TARGET  = 1450;
  localparam int HOLD_AT      = 400;   // receiver hold-off starts here
  localparam int DENSE_SPAN   = 300;   // items with no random idling on either side
  localparam int DRAIN_AT     = 1000;  // sender waits for every result here
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;
  localparam int WATCHDOG_MAX = 3000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [SLOT_W-1:0]        slot;
    logic                     idle;
    logic [READY_W-1:0]       ready;
    logic signed [NICE_W-1:0] nice;
  } sched_event_t;

  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [RCPU_W-1:0] recent_x100;
    logic [LAVG_W-1:0]        load_x100;
    logic signed [NICE_W-1:0] nice;
  } slot_report_t;

  typedef struct packed {
    sched_event_t ev;
    logic         typed;
    slot_report_t want;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind;
  logic [SLOT_W-1:0]        slot;
  logic                     running_is_idle;
  logic [READY_W-1:0]       ready_count;
  logic signed [NICE_W-1:0] nice_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [PRIO_W-1:0]        priority_res;
  logic signed [RCPU_W-1:0] recent_cpu_x100;
  logic [LAVG_W-1:0]        load_avg_x100;
  logic signed [NICE_W-1:0] nice_out;

  mlfqs_load_and_cpu_accounting dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .slot            (slot),
    .running_is_idle (running_is_idle),
    .ready_count     (ready_count),
    .nice_value      (nice_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .priority_res    (priority_res),
    .recent_cpu_x100 (recent_cpu_x100),
    .load_avg_x100   (load_avg_x100),
    .nice_out        (nice_out)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Estimator shadow state: load in fixed point and the three per-slot tables.
  // ---------------------------------------------------------------------------
  longint load_fix;
  longint cpu_fix [SLOT_COUNT];
  longint nice_tab [SLOT_COUNT];
  longint prio_tab [SLOT_COUNT];

  slot_report_t pending_reports [$];

  int  items_sent  = 0;
  int  fail_count  = 0;
  int  quiet_count = 0;
  int  hold_left   = 0;
  bit  hold_done   = 1'b0;
  bit  hold_request = 1'b0;
  bit  steady_flow  = 1'b0;

  function automatic longint clamp_i32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  // Round a fixed-point value to an integer, ties away from zero
  function automatic longint round_fix(longint x);
    if (x >= 0) return (x + FIX_ONE / 2) / FIX_ONE;
    return (x - FIX_ONE / 2) / FIX_ONE;
  endfunction

  function automatic void reprioritize(int s);
    longint p;
    p = TOP_PRIORITY - round_fix(cpu_fix[s] / 4) - 2 * nice_tab[s];
    if (p < 0) p = 0;
    if (p > TOP_PRIORITY) p = TOP_PRIORITY;
    prio_tab[s] = p;
  endfunction

  // Apply one event to the shadow state and return the slot report it yields
  function automatic slot_report_t step_estimates(sched_event_t ev);
    int           s;
    longint       nv;
    longint       runnable;
    longint       added;
    longint       dbl;
    longint       coef;
    longint       t;
    slot_report_t rep;
    s  = int'(ev.slot) % SLOT_COUNT;
    nv = longint'($signed(ev.nice));
    case (ev.kind)
      KIND_TICK: begin
        if (!ev.idle) cpu_fix[s] = clamp_i32(cpu_fix[s] + FIX_ONE);
      end
      KIND_LOAD: begin
        runnable = longint'(ev.ready) + (ev.idle ? 0 : 1);
        added = BLEND_ADD * runnable;
        if (FRAC_BITS >= BLEND_FRAC) added = added << (FRAC_BITS - BLEND_FRAC);
        else added = added >> (BLEND_FRAC - FRAC_BITS);
        t = ((BLEND_KEEP * load_fix) >> BLEND_FRAC) + added;
        load_fix = (t > I32_MAX) ? I32_MAX : t;
      end
      KIND_DECAY: begin
        dbl  = 2 * load_fix;
        coef = (dbl * FIX_ONE) / (dbl + FIX_ONE);
        t    = (coef * cpu_fix[s]) / FIX_ONE;
        cpu_fix[s] = clamp_i32(t + nice_tab[s] * FIX_ONE);
      end
      KIND_NICE: begin
        if (nv < NICE_MIN) nv = NICE_MIN;
        if (nv > NICE_MAX) nv = NICE_MAX;
        nice_tab[s] = nv;
        reprioritize(s);
      end
      KIND_PRIO: begin
        reprioritize(s);
      end
      default: begin
      end
    endcase
    t = prio_tab[s];
    rep.prio = t[PRIO_W-1:0];
    t = clamp_i32(round_fix(cpu_fix[s] * 100));
    rep.recent_x100 = t[RCPU_W-1:0];
    t = round_fix(load_fix * 100);
    rep.load_x100 = t[LAVG_W-1:0];
    t = nice_tab[s];
    rep.nice = t[NICE_W-1:0];
    return rep;
  endfunction

  function automatic sched_event_t make_event(logic [KIND_W-1:0] k, int s, bit idle,
                                              int ready, int nv);
    sched_event_t ev;
    ev.kind  = k;
    ev.slot  = SLOT_W'(s);
    ev.idle  = idle;
    ev.ready = READY_W'(ready);
    ev.nice  = NICE_W'(nv);
    return ev;
  endfunction

  function automatic slot_report_t report(int prio, int recent, int load, int nv);
    slot_report_t rep;
    rep.prio        = PRIO_W'(prio);
    rep.recent_x100 = RCPU_W'(recent);
    rep.load_x100   = LAVG_W'(load);
    rep.nice        = NICE_W'(nv);
    return rep;
  endfunction

  // Row whose result can be read off by hand
  function automatic directed_row_t fixed_row(sched_event_t ev, slot_report_t want);
    directed_row_t r;
    r.ev    = ev;
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // Row whose result comes from the shadow state
  function automatic directed_row_t derived_row(sched_event_t ev);
    directed_row_t r;
    r.ev    = ev;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // Random field values; ready and nice mostly stay inside their legal range
  function automatic int rand_ready();
    if ($urandom_range(9) == 0) return int'($urandom_range(127, 65));
    return int'($urandom_range(64));
  endfunction

  function automatic int rand_nice();
    if ($urandom_range(99) < 15) return int'($urandom_range(63));
    return int'($urandom_range(40)) - 20;
  endfunction

  // Favor one hot slot so that recent CPU builds up far enough to clamp priority
  function automatic int pick_slot(int hot);
    int r;
    r = int'($urandom_range(99));
    if (r < 60) return hot;
    if (r < 85) return int'($urandom_range(7));
    return int'($urandom_range(SLOT_COUNT - 1));
  endfunction

  function automatic bit rand_idle(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then queue the report it must yield.
  // Pacing (idle gaps, hold-off, dense stretch, drain) is decided per item here.
  // ---------------------------------------------------------------------------
  task automatic send(sched_event_t ev, bit typed, slot_report_t want);
    slot_report_t rep;
    int           gap;
    in_valid        <= 1'b1;
    kind            <= ev.kind;
    slot            <= ev.slot;
    running_is_idle <= ev.idle;
    ready_count     <= ev.ready;
    nice_value      <= ev.nice;
    do @(posedge clk); while (in_stall);
    rep = step_estimates(ev);
    pending_reports.push_back(typed ? want : rep);
    items_sent++;

    if (items_sent == HOLD_AT) begin
      hold_request <= 1'b1;
      steady_flow  <= 1'b1;
    end
    if (items_sent == HOLD_AT + DENSE_SPAN) steady_flow <= 1'b0;

    if (items_sent == DRAIN_AT) begin
      // Drop valid and wait for the block to empty completely
      in_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clk);
    end else begin
      gap = 0;
      while (!steady_flow && $urandom_range(99) < 38) gap++;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off as the dense stretch opens, no random stalls in it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(99) < 38);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Compare each taken result with the oldest
  // queued report; end the run if nothing moves for too long.
  // ---------------------------------------------------------------------------
  slot_report_t oldest;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: prio %0d recent %0d load %0d nice %0d",
                   priority_res, recent_cpu_x100, load_avg_x100, nice_out);
      end else begin
        oldest = pending_reports.pop_front();
        if (priority_res !== oldest.prio || recent_cpu_x100 !== oldest.recent_x100 ||
            load_avg_x100 !== oldest.load_x100 || nice_out !== oldest.nice) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: got prio %0d recent %0d load %0d nice %0d, %s %0d %0d %0d %0d",
                     priority_res, recent_cpu_x100, load_avg_x100, nice_out, "expected",
                     oldest.prio, oldest.recent_x100, oldest.load_x100, oldest.nice);
        end
      end
    end

    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WATCHDOG_MAX) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_MAX);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then scheduler-like epochs with noise.
  // ---------------------------------------------------------------------------
  directed_row_t plan [$];

  initial begin
    int hot;
    int s;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    kind            <= KIND_TICK;
    slot            <= '0;
    running_is_idle <= 1'b0;
    ready_count     <= '0;
    nice_value      <= '0;

    load_fix = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cpu_fix[i]  = 0;
      nice_tab[i] = 0;
      prio_tab[i] = TOP_PRIORITY;
    end

    // Fresh state: every slot at top priority, nothing charged, load zero
    plan.push_back(fixed_row(make_event(KIND_PRIO, 0, 0, 0, 0), report(63, 0, 0, 0)));
    // Tick while idle charges nothing
    plan.push_back(fixed_row(make_event(KIND_TICK, 5, 1, 0, 0), report(63, 0, 0, 0)));
    // One tick is 1.0 recent CPU; priority is not recomputed by a tick
    plan.push_back(fixed_row(make_event(KIND_TICK, 63, 0, 0, 0), report(63, 100, 0, 0)));
    plan.push_back(fixed_row(make_event(KIND_NICE, 63, 0, 0, 20), report(23, 100, 0, 20)));
    // Nice below range clamps to -20, priority clamps at the top
    plan.push_back(fixed_row(make_event(KIND_NICE, 1, 0, 0, -32), report(63, 0, 0, -20)));
    // Nice above range clamps to 20
    plan.push_back(fixed_row(make_event(KIND_NICE, 2, 0, 0, 31), report(23, 0, 0, 20)));
    plan.push_back(derived_row(make_event(KIND_NICE, 21, 0, 0, -21)));
    // First load update with only the running thread: load 273/16384
    plan.push_back(fixed_row(make_event(KIND_LOAD, 1, 0, 0, 0), report(63, 0, 2, -20)));
    plan.push_back(derived_row(make_event(KIND_DECAY, 63, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_DECAY, 1, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_PRIO, 1, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_LOAD, 0, 1, 127, 0)));
    plan.push_back(derived_row(make_event(KIND_LOAD, 42, 0, 64, -1)));
    plan.push_back(derived_row(make_event(KIND_LOAD, 21, 0, 127, 31)));
    // Unused codes leave everything alone
    plan.push_back(derived_row(make_event(KIND_RSVD5, 10, 1, 127, -1)));
    plan.push_back(derived_row(make_event(KIND_RSVD6, 42, 0, 85, -32)));
    plan.push_back(derived_row(make_event(KIND_RSVD7, 63, 1, 42, 31)));
    plan.push_back(derived_row(make_event(KIND_TICK, 0, 0, 127, -32)));
    plan.push_back(derived_row(make_event(KIND_DECAY, 2, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_PRIO, 2, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_NICE, 0, 0, 0, 0)));
    plan.push_back(derived_row(make_event(KIND_PRIO, 63, 1, 127, -32)));
    plan.push_back(derived_row(make_event(KIND_DECAY, 0, 1, 127, 31)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send(plan[i].ev, plan[i].typed, plan[i].want);

    // Each epoch mimics one scheduler second: ticks on the running thread, a
    // load update, decay and recompute over a few slots, now and then a nice
    // change and a stray item with any code.
    while (items_sent < ITEM_TARGET) begin
      hot = int'($urandom_range(7));
      repeat ($urandom_range(8, 1))
        send(make_event(KIND_TICK, pick_slot(hot), rand_idle(15), rand_ready(), rand_nice()),
             1'b0, '0);
      send(make_event(KIND_LOAD, pick_slot(hot), rand_idle(20), rand_ready(), rand_nice()),
           1'b0, '0);
      repeat ($urandom_range(4, 1)) begin
        s = pick_slot(hot);
        send(make_event(KIND_DECAY, s, rand_idle(20), rand_ready(), rand_nice()), 1'b0, '0);
        send(make_event(KIND_PRIO, s, rand_idle(20), rand_ready(), rand_nice()), 1'b0, '0);
      end
      if ($urandom_range(99) < 30)
        send(make_event(KIND_NICE, pick_slot(hot), rand_idle(20), rand_ready(), rand_nice()),
             1'b0, '0);
      if ($urandom_range(99) < 15)
        send(make_event(KIND_W'($urandom_range(7)), int'($urandom_range(SLOT_COUNT - 1)),
                        rand_idle(50), int'($urandom_range(127)), int'($urandom_range(63))),
             1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Hold a little longer to catch any stray result
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
